FILE: design/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
package rau_pkg;

   typedef logic [2:0] opcode_type;
   typedef logic [1:0] status_type;

   // Operation codes
   localparam opcode_type OP_ADD = 3'd0;
   localparam opcode_type OP_SUB = 3'd1;
   localparam opcode_type OP_MUL = 3'd2;
   localparam opcode_type OP_DIV = 3'd3;
   localparam opcode_type OP_EQ  = 3'd4;

   // Result status codes
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_ZERO_DEN = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;

endpackage

FILE: design/rau_if.sv
// Request and response channel interfaces of the rational arithmetic unit.
interface rau_req_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   rau_pkg::opcode_type         opcode;
   logic signed [WORD_BITS-1:0] a_num;
   logic signed [WORD_BITS-1:0] a_den;
   logic signed [WORD_BITS-1:0] b_num;
   logic signed [WORD_BITS-1:0] b_den;

   modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] res_num;
   logic signed [WORD_BITS-1:0] res_den;
   logic                        equal;
   rau_pkg::status_type         status;

   modport source (output valid, res_num, res_den, equal, status, input ready);
   modport sink   (input valid, res_num, res_den, equal, status, output ready);
endinterface

FILE: design/rational_arith_unit.sv
// Rational arithmetic unit: fraction add/sub/mul/div with GCD reduction, and equality test.
// Opcodes 0-3 form the products on the shared WORD_BITS x WORD_BITS multiplier, combine them
// (a zero denominator ends there), then run a data-dependent binary GCD loop and restoring
// division (both skipped for a zero numerator) and a range check; opcode 4 and unused codes answer from idle.
// Throughput: one transaction at a time; req.ready is high only while no transaction is held.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp.valid.
module rational_arith_unit #(
   parameter int WORD_BITS = 32
) (
   input logic      clock,
   input logic      reset,
   rau_req_if.sink  req,
   rau_rsp_if.source rsp
);

   localparam int WideBits = 2 * WORD_BITS;
   localparam int CntBits  = $clog2(WideBits + 1);
   localparam logic [WideBits-1:0] WTop = {{(WideBits-1){1'b0}}, 1'b1} << (WORD_BITS - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_COMB  = 3'd2;
   localparam logic [2:0] S_GCD   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   // Control state
   logic [2:0]            state_ff, state_in;
   logic [1:0]            step_ff, step_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Operand registers, sign and magnitude
   rau_pkg::opcode_type   op_ff, op_in;
   logic                  an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic                  an_neg_in, ad_neg_in, bn_neg_in, bd_neg_in;
   logic [WORD_BITS-1:0]  an_ff, ad_ff, bn_ff, bd_ff;
   logic [WORD_BITS-1:0]  an_in, ad_in, bn_in, bd_in;

   // Products
   logic [WideBits-1:0]   p_ff, q_ff, den_ff, p_in, q_in, den_in;
   logic                  p_neg_ff, q_neg_ff, den_neg_ff, p_neg_in, q_neg_in, den_neg_in;
   logic                  num_neg_ff, num_neg_in;

   // GCD and division working registers
   logic [WideBits-1:0]   x_ff, y_ff, n_ff, d_ff, rn_ff, rd_ff;
   logic [WideBits-1:0]   x_in, y_in, n_in, d_in, rn_in, rd_in;

   // Result registers
   logic [WORD_BITS-1:0]  res_num_ff, res_den_ff, res_num_in, res_den_in;
   logic                  equal_ff, equal_in;
   rau_pkg::status_type   status_ff, status_in;

   // Shared multiplier and datapath signals
   logic [WORD_BITS-1:0]  mul_a, mul_b;
   logic [WideBits-1:0]   prod;
   logic                  prod_neg;
   logic [WideBits:0]     diff_xy;
   logic [WideBits:0]     trial_n, trial_d, sub_n, sub_d;
   logic [WideBits-1:0]   sum_mag;
   logic                  sum_neg;
   logic                  is_addsub;
   logic                  num_fits, den_fits;

   function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] v);
      mag_of = v[WORD_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   assign is_addsub = (op_ff == rau_pkg::OP_ADD) || (op_ff == rau_pkg::OP_SUB);

   // Select multiplier operands for the current step
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      prod_neg = 1'b0;
      case (step_ff)
         2'd0: begin
            mul_a = an_ff;
            if (op_ff == rau_pkg::OP_MUL) begin
               mul_b    = bn_ff;
               prod_neg = an_neg_ff ^ bn_neg_ff;
            end else begin
               mul_b    = bd_ff;
               prod_neg = an_neg_ff ^ bd_neg_ff;
            end
         end
         2'd1: begin
            mul_a = ad_ff;
            if (op_ff == rau_pkg::OP_DIV) begin
               mul_b    = bn_ff;
               prod_neg = ad_neg_ff ^ bn_neg_ff;
            end else begin
               mul_b    = bd_ff;
               prod_neg = ad_neg_ff ^ bd_neg_ff;
            end
         end
         2'd2: begin
            mul_a    = is_addsub ? bn_ff : '0;
            mul_b    = ad_ff;
            prod_neg = bn_neg_ff ^ ad_neg_ff ^ (op_ff == rau_pkg::OP_SUB);
         end
         default: begin
            mul_a    = '0;
            mul_b    = '0;
            prod_neg = 1'b0;
         end
      endcase
   end

   assign prod = {{WORD_BITS{1'b0}}, mul_a} * {{WORD_BITS{1'b0}}, mul_b};

   // Signed-magnitude sum of the two numerator products
   always_comb begin
      if (p_neg_ff == q_neg_ff) begin
         sum_mag = p_ff + q_ff;
         sum_neg = p_neg_ff;
      end else if (p_ff >= q_ff) begin
         sum_mag = p_ff - q_ff;
         sum_neg = p_neg_ff;
      end else begin
         sum_mag = q_ff - p_ff;
         sum_neg = q_neg_ff;
      end
   end

   // Shared compare/subtract for the GCD loop, and the two restoring division steps
   assign diff_xy = {1'b0, x_ff} - {1'b0, y_ff};
   assign trial_n = {rn_ff, n_ff[WideBits-1]};
   assign trial_d = {rd_ff, d_ff[WideBits-1]};
   assign sub_n   = trial_n - {1'b0, x_ff};
   assign sub_d   = trial_d - {1'b0, x_ff};

   // Range check of the reduced parts
   assign num_fits = num_neg_ff ? (n_ff <= WTop) : (n_ff < WTop);
   assign den_fits = den_neg_ff ? (d_ff <= WTop) : (d_ff < WTop);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      an_neg_in    = an_neg_ff;
      ad_neg_in    = ad_neg_ff;
      bn_neg_in    = bn_neg_ff;
      bd_neg_in    = bd_neg_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      den_in       = den_ff;
      p_neg_in     = p_neg_ff;
      q_neg_in     = q_neg_ff;
      den_neg_in   = den_neg_ff;
      num_neg_in   = num_neg_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      equal_in     = equal_ff;
      status_in    = status_ff;

      case (state_ff)
         S_IDLE: begin
            // Take a transaction and split operands into sign and magnitude
            if (req.valid) begin
               op_in      = req.opcode;
               an_neg_in  = req.a_num[WORD_BITS-1];
               ad_neg_in  = req.a_den[WORD_BITS-1];
               bn_neg_in  = req.b_num[WORD_BITS-1];
               bd_neg_in  = req.b_den[WORD_BITS-1];
               an_in      = mag_of(req.a_num);
               ad_in      = mag_of(req.a_den);
               bn_in      = mag_of(req.b_num);
               bd_in      = mag_of(req.b_den);
               res_num_in = '0;
               res_den_in = '0;
               status_in  = rau_pkg::STATUS_OK;
               equal_in   = 1'b0;
               step_in    = 2'd0;
               if (req.opcode == rau_pkg::OP_EQ) begin
                  equal_in     = (req.a_num == req.b_num) && (req.a_den == req.b_den);
                  rsp_valid_in = 1'b1;
                  state_in     = S_OUT;
               end else if (req.opcode > rau_pkg::OP_EQ) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_OUT;
               end else begin
                  state_in = S_MUL;
               end
            end
         end

         S_MUL: begin
            // One product per cycle on the shared multiplier
            case (step_ff)
               2'd0: begin
                  p_in     = prod;
                  p_neg_in = prod_neg && (prod != '0);
               end
               2'd1: begin
                  den_in     = prod;
                  den_neg_in = prod_neg && (prod != '0);
               end
               default: begin
                  q_in     = prod;
                  q_neg_in = prod_neg && (prod != '0);
               end
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = S_COMB;
            end
         end

         S_COMB: begin
            // Form the numerator, catch a zero denominator or zero numerator
            num_neg_in = sum_neg && (sum_mag != '0);
            x_in       = sum_mag;
            y_in       = den_ff;
            n_in       = sum_mag;
            d_in       = den_ff;
            if (den_ff == '0) begin
               status_in    = rau_pkg::STATUS_ZERO_DEN;
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end else if (sum_mag == '0) begin
               state_in = S_CHECK;
            end else begin
               state_in = S_GCD;
            end
         end

         S_GCD: begin
            // Binary GCD; strip common factors of two from the result parts as well
            if (x_ff == y_ff) begin
               rn_in    = '0;
               rd_in    = '0;
               cnt_in   = CntBits'(WideBits);
               state_in = S_DIV;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               n_in = n_ff >> 1;
               d_in = d_ff >> 1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!diff_xy[WideBits]) begin
               x_in = diff_xy[WideBits-1:0];
            end else begin
               y_in = y_ff - x_ff;
            end
         end

         S_DIV: begin
            // One quotient bit of each part per cycle; quotients shift into n and d
            if (!sub_n[WideBits]) begin
               rn_in = sub_n[WideBits-1:0];
               n_in  = {n_ff[WideBits-2:0], 1'b1};
            end else begin
               rn_in = trial_n[WideBits-1:0];
               n_in  = {n_ff[WideBits-2:0], 1'b0};
            end
            if (!sub_d[WideBits]) begin
               rd_in = sub_d[WideBits-1:0];
               d_in  = {d_ff[WideBits-2:0], 1'b1};
            end else begin
               rd_in = trial_d[WideBits-1:0];
               d_in  = {d_ff[WideBits-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntBits'(1)) begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            // Flag overflow or convert back to two's complement
            if (num_fits && den_fits) begin
               res_num_in = num_neg_ff ? (~n_ff[WORD_BITS-1:0] + 1'b1) : n_ff[WORD_BITS-1:0];
               res_den_in = den_neg_ff ? (~d_ff[WORD_BITS-1:0] + 1'b1) : d_ff[WORD_BITS-1:0];
            end else begin
               status_in = rau_pkg::STATUS_OVERFLOW;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end

         S_OUT: begin
            // Hold the result until it is taken
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            rsp_valid_in = 1'b0;
            state_in     = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff    <= step_in;
      cnt_ff     <= cnt_in;
      op_ff      <= op_in;
      an_neg_ff  <= an_neg_in;
      ad_neg_ff  <= ad_neg_in;
      bn_neg_ff  <= bn_neg_in;
      bd_neg_ff  <= bd_neg_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      den_ff     <= den_in;
      p_neg_ff   <= p_neg_in;
      q_neg_ff   <= q_neg_in;
      den_neg_ff <= den_neg_in;
      num_neg_ff <= num_neg_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      equal_ff   <= equal_in;
      status_ff  <= status_in;
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.res_num = res_num_ff;
   assign rsp.res_den = res_den_ff;
   assign rsp.equal   = equal_ff;
   assign rsp.status  = status_ff;

endmodule

FILE: design/rau_checker.sv
// Port-level checks for the rational arithmetic unit, bound into every rational_arith_unit instance.
module rau_checker #(
   parameter int WORD_BITS = 32
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WORD_BITS-1:0] rsp_res_num,
   input logic [WORD_BITS-1:0] rsp_res_den,
   input logic                 rsp_equal,
   input rau_pkg::status_type  rsp_status
);

   // One transaction in flight: never ready while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a result is pending");

   // Accepting a transaction closes the request side next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("still ready after accepting a transaction");

   // An equality result carries zero parts and ok status
   a_equal_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_equal) |->
         (rsp_res_num == '0 && rsp_res_den == '0 && rsp_status == rau_pkg::STATUS_OK))
      else $error("equality result with non-zero parts or status");

   // An error result carries zero parts and never sets equal
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rau_pkg::STATUS_OK) |->
         (rsp_res_num == '0 && rsp_res_den == '0 && !rsp_equal))
      else $error("error result with non-zero parts");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before it was taken");

endmodule

bind rational_arith_unit rau_checker #(.WORD_BITS(WORD_BITS)) u_rau_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_res_num (rsp.res_num),
   .rsp_res_den (rsp.res_den),
   .rsp_equal   (rsp.equal),
   .rsp_status  (rsp.status)
);

FILE: dv/tb.sv
// Self-checking testbench for the rational arithmetic unit: directed and random fraction traffic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_BITS      = 32;
   localparam int MISMATCH_SHOWN = 10;
   // Limit covers the worst transaction's block work plus stalls on both sides
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 400;

   // Codes the block answers with an all-zero result
   localparam rau_pkg::opcode_type OP_SPARE_FIRST = 3'd5;
   localparam rau_pkg::opcode_type OP_SPARE_LAST  = 3'd7;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type WORD_MAX = ~WORD_MIN;

   typedef struct {
      rau_pkg::opcode_type opcode;
      word_type            a_num;
      word_type            a_den;
      word_type            b_num;
      word_type            b_den;
   } fraction_op_type;

   typedef struct {
      word_type            res_num;
      word_type            res_den;
      logic                equal;
      rau_pkg::status_type status;
   } fraction_result_type;

   // Sign and full 64-bit magnitude, wide enough for any cross product or sum
   typedef struct {
      bit        neg;
      bit [63:0] mag;
   } signed_mag_type;

   logic clock;
   logic reset;
   bit   no_idle;
   int   mismatch_count;
   int   idle_cycles;

   fraction_result_type pending_results[$];

   rau_req_if #(.WORD_BITS(WORD_BITS)) req_ch ();
   rau_rsp_if #(.WORD_BITS(WORD_BITS)) rsp_ch ();

   rational_arith_unit #(.WORD_BITS(WORD_BITS)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // 100 MHz clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Fraction arithmetic in sign-magnitude form

   function automatic signed_mag_type to_sign_mag(word_type v);
      signed_mag_type r;
      bit [63:0]      raw;
      raw = '0;
      raw[WORD_BITS-1:0] = v;
      r.neg = v[WORD_BITS-1];
      r.mag = r.neg ? ((64'd1 << WORD_BITS) - raw) : raw;
      return r;
   endfunction

   function automatic signed_mag_type mag_product(signed_mag_type x, signed_mag_type y);
      signed_mag_type r;
      r.mag = x.mag * y.mag;
      r.neg = (x.neg != y.neg) && (r.mag != 0);
      return r;
   endfunction

   function automatic signed_mag_type mag_sum(signed_mag_type x, signed_mag_type y);
      signed_mag_type r;
      if (x.neg == y.neg) begin
         r.mag = x.mag + y.mag;
         r.neg = x.neg;
      end else if (x.mag >= y.mag) begin
         r.mag = x.mag - y.mag;
         r.neg = x.neg;
      end else begin
         r.mag = y.mag - x.mag;
         r.neg = y.neg;
      end
      if (r.mag == 0) r.neg = 1'b0;
      return r;
   endfunction

   // Euclid over magnitudes; a zero part reduces by one
   function automatic bit [63:0] common_divisor(bit [63:0] x, bit [63:0] y);
      bit [63:0] t;
      if (x == 0 || y == 0) return 64'd1;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic bit fits_word(signed_mag_type v);
      return v.neg ? (v.mag <= (64'd1 << (WORD_BITS-1)))
                   : (v.mag < (64'd1 << (WORD_BITS-1)));
   endfunction

   function automatic word_type to_word(signed_mag_type v);
      return v.neg ? word_type'(~v.mag + 64'd1) : word_type'(v.mag);
   endfunction

   function automatic fraction_result_type compute_fraction_result(fraction_op_type op);
      fraction_result_type r;
      signed_mag_type      an, ad, bn, bd, p, q, num, den;
      bit [63:0]           g;
      r = '{res_num: '0, res_den: '0, equal: 1'b0, status: rau_pkg::STATUS_OK};
      an = to_sign_mag(op.a_num);
      ad = to_sign_mag(op.a_den);
      bn = to_sign_mag(op.b_num);
      bd = to_sign_mag(op.b_den);
      case (op.opcode)
         rau_pkg::OP_EQ: begin
            r.equal = (op.a_num == op.b_num) && (op.a_den == op.b_den);
            return r;
         end
         rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
            p = mag_product(an, bd);
            q = mag_product(bn, ad);
            if (op.opcode == rau_pkg::OP_SUB && q.mag != 0) q.neg = !q.neg;
            num = mag_sum(p, q);
            den = mag_product(ad, bd);
         end
         rau_pkg::OP_MUL: begin
            num = mag_product(an, bn);
            den = mag_product(ad, bd);
         end
         rau_pkg::OP_DIV: begin
            num = mag_product(an, bd);
            den = mag_product(ad, bn);
         end
         default: return r;
      endcase
      if (den.mag == 0) begin
         r.status = rau_pkg::STATUS_ZERO_DEN;
         return r;
      end
      g = common_divisor(num.mag, den.mag);
      num.mag = num.mag / g;
      den.mag = den.mag / g;
      if (!fits_word(num) || !fits_word(den)) begin
         r.status = rau_pkg::STATUS_OVERFLOW;
         return r;
      end
      r.res_num = to_word(num);
      r.res_den = to_word(den);
      return r;
   endfunction

   // Stimulus helpers

   function automatic fraction_op_type make_op(rau_pkg::opcode_type opc, word_type an,
                                               word_type ad, word_type bn, word_type bd);
      fraction_op_type op;
      op.opcode = opc;
      op.a_num  = an;
      op.a_den  = ad;
      op.b_num  = bn;
      op.b_den  = bd;
      return op;
   endfunction

   // Mix of extremes, full-width, small and mid-sized values
   function automatic word_type draw_part(bit allow_zero);
      word_type           v;
      logic signed [15:0] h;
      int                 k;
      k = $urandom_range(0, 4);
      case ($urandom_range(0, 9))
         0: begin
            if (k == 0) v = WORD_MIN;
            else if (k == 1) v = WORD_MAX;
            else if (k == 2) v = -1;
            else if (k == 3) v = 1;
            else v = 0;
         end
         1, 2: v = word_type'($urandom);
         3, 4, 5: v = word_type'(int'($urandom_range(0, 24)) - 12);
         6, 7: begin
            h = 16'($urandom);
            v = word_type'(h);
         end
         default: begin
            v = word_type'($urandom_range(0, 5000));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      if (!allow_zero && v == 0) v = 1;
      return v;
   endfunction

   // Present one transaction after a random gap and hold it until accepted
   task automatic send_fraction_op(input fraction_op_type op);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.opcode = op.opcode;
      req_ch.a_num  = op.a_num;
      req_ch.a_den  = op.a_den;
      req_ch.b_num  = op.b_num;
      req_ch.b_den  = op.b_den;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(compute_fraction_result(op));
   endtask

   // Test tasks

   task automatic test_directed_cases();
      send_fraction_op(make_op(rau_pkg::OP_ADD, 1, 2, 1, 3));
      send_fraction_op(make_op(rau_pkg::OP_SUB, 1, 2, 1, 2));      // zero numerator
      send_fraction_op(make_op(rau_pkg::OP_MUL, 2, 3, 3, 4));
      send_fraction_op(make_op(rau_pkg::OP_DIV, 1, 2, 1, 4));
      send_fraction_op(make_op(rau_pkg::OP_SUB, -7, 3, 5, -6));
      send_fraction_op(make_op(rau_pkg::OP_EQ, 3, 4, 3, 4));
      send_fraction_op(make_op(rau_pkg::OP_EQ, 3, 4, 6, 8));       // equal value, other parts
      send_fraction_op(make_op(rau_pkg::OP_EQ, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
      send_fraction_op(make_op(rau_pkg::OP_EQ, -1, WORD_MIN, -1, WORD_MAX));
      send_fraction_op(make_op(rau_pkg::OP_ADD, 5, 0, 1, 3));      // zero operand denominator
      send_fraction_op(make_op(rau_pkg::OP_MUL, 5, 7, 1, 0));
      send_fraction_op(make_op(rau_pkg::OP_DIV, 3, 4, 0, 9));      // division by zero fraction
      send_fraction_op(make_op(rau_pkg::OP_ADD, WORD_MAX, 1, WORD_MAX, 1)); // overflow
      send_fraction_op(make_op(rau_pkg::OP_MUL, WORD_MIN, 1, -1, 1));       // overflow on negation
      send_fraction_op(make_op(rau_pkg::OP_MUL, WORD_MIN, 1, 1, 1));
      send_fraction_op(make_op(rau_pkg::OP_MUL, 1, -1, 1, 1));     // negative denominator kept
      send_fraction_op(make_op(rau_pkg::OP_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN));
      send_fraction_op(make_op(rau_pkg::OP_ADD, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN));
      send_fraction_op(make_op(rau_pkg::OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
      send_fraction_op(make_op(rau_pkg::OP_DIV, WORD_MAX, -1, -1, WORD_MAX));
      send_fraction_op(make_op(rau_pkg::OP_MUL, 0, 5, 7, 3));
      send_fraction_op(make_op(rau_pkg::OP_ADD, 0, -1, 0, -1));
      for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++) begin
         send_fraction_op(make_op(rau_pkg::opcode_type'(k), 3, 4, 5, 6));
      end
   endtask

   // Well-formed operations with nonzero denominators
   task automatic test_random_fractions(input int count);
      fraction_op_type op;
      repeat (count) begin
         op = make_op(rau_pkg::opcode_type'($urandom_range(rau_pkg::OP_ADD, rau_pkg::OP_EQ)),
                      draw_part(1'b1), draw_part(1'b0), draw_part(1'b1), draw_part(1'b0));
         if (op.opcode == rau_pkg::OP_EQ && $urandom_range(0, 1)) begin
            op.b_num = op.a_num;
            op.b_den = op.a_den;
         end
         send_fraction_op(op);
      end
   endtask

   // Any opcode, zero denominators allowed, some parts raw random
   task automatic test_malformed_items(input int count);
      fraction_op_type op;
      repeat (count) begin
         op = make_op(rau_pkg::opcode_type'($urandom_range(0, 7)), draw_part(1'b1),
                      draw_part(1'b1), draw_part(1'b1), draw_part(1'b1));
         if ($urandom_range(0, 1)) op.a_den = word_type'($urandom);
         if ($urandom_range(0, 1)) op.b_num = word_type'($urandom);
         send_fraction_op(op);
      end
   endtask

   // Hold both sides ready for a run of transactions
   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      test_random_fractions(count);
      no_idle = 1'b0;
   endtask

   // Result checking

   task automatic note_mismatch(input string what, input longint expected_v,
                                input longint actual_v);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, expected_v,
                  actual_v);
   endtask

   task automatic check_fraction_result();
      fraction_result_type want;
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MISMATCH_SHOWN)
            $display("%0t: result with nothing outstanding, num %0d den %0d", $realtime,
                     rsp_ch.res_num, rsp_ch.res_den);
         return;
      end
      want = pending_results.pop_front();
      if (rsp_ch.res_num !== want.res_num) note_mismatch("res_num", want.res_num, rsp_ch.res_num);
      if (rsp_ch.res_den !== want.res_den) note_mismatch("res_den", want.res_den, rsp_ch.res_den);
      if (rsp_ch.equal !== want.equal) note_mismatch("equal", want.equal, rsp_ch.equal);
      if (rsp_ch.status !== want.status) note_mismatch("status", want.status, rsp_ch.status);
   endtask

   // Drain results: check at the rising edge, stall ready at the falling edge
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            check_fraction_result();
            stall = no_idle ? 0 : $urandom_range(0, 10);
         end
         @(negedge clock);
         if (reset) begin
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = (stall == 0);
            if (rsp_ch.valid === 1'b1 && stall > 0) stall--;
         end
      end
   end

   // Abort when no transaction moves on either side for too long
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Sequence the tests
   initial begin
      reset          = 1'b1;
      no_idle        = 1'b0;
      mismatch_count = 0;
      idle_cycles    = 0;
      req_ch.valid   = 1'b0;
      req_ch.opcode  = rau_pkg::OP_ADD;
      req_ch.a_num   = '0;
      req_ch.a_den   = '0;
      req_ch.b_num   = '0;
      req_ch.b_den   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_fractions(460);
      test_malformed_items(80);
      test_back_to_back(40);

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
design/rau_pkg.sv
design/rau_if.sv
design/rational_arith_unit.sv
design/rau_checker.sv
dv/tb.sv
